FILE: hw/rtl/ghsd_pkg.sv
// Shared types, constants and field layout for the gait heel-strike detector.
// No dependencies; imported by every module of the block.
package ghsd_pkg;

    localparam int STEPS_TO_READY_DEF = 5;
    localparam int TIME_WIDTH_DEF     = 32;

    localparam int THR_W      = 16;
    localparam int SAMPLE_W   = 16;
    localparam int TIME_OUT_W = 32;
    localparam int HIST_W     = 15;
    localparam int MEAN_W     = 14;
    localparam int STEP_W     = 3;
    localparam int CFG_IDX_W  = 3;

    localparam logic [HIST_W-1:0] INTERVAL_MAX = 15'h7fff;
    // floor(x / 3) == (x * RECIP3) >> RECIP3_SHIFT for x <= 32768
    localparam logic [15:0] RECIP3       = 16'd43691;
    localparam int          RECIP3_SHIFT = 17;

    // input item layout
    localparam int S_TDATA_W = 96;
    localparam int IN_TIME_LO = 0;
    localparam int IN_LF_LO   = 32;
    localparam int IN_LS_LO   = 48;
    localparam int IN_RF_LO   = 64;
    localparam int IN_RS_LO   = 80;

    // result item layout
    localparam int M_TDATA_W   = 104;
    localparam int OUT_LST_BIT = 0;
    localparam int OUT_RST_BIT = 1;
    localparam int OUT_LT_LO   = 2;
    localparam int OUT_RT_LO   = 34;
    localparam int OUT_LM_LO   = 66;
    localparam int OUT_RM_LO   = 80;
    localparam int OUT_STEP_LO = 94;
    localparam int OUT_RDY_BIT = 97;

    typedef enum logic [CFG_IDX_W-1:0] {
        REG_LEFT_FORCE_THR  = 3'd0,
        REG_LEFT_SLOPE_THR  = 3'd1,
        REG_RIGHT_FORCE_THR = 3'd2,
        REG_RIGHT_SLOPE_THR = 3'd3,
        REG_PROSTH_ON_LEFT  = 3'd4
    } cfg_reg_t;

    typedef struct packed {
        logic a_load;   // item enters the update stage
        logic b_load;   // update stage moves to the output stage
    } pipe_ctrl_t;

    typedef struct packed {
        logic                  stance;
        logic [TIME_OUT_W-1:0] strike_time;
        logic [MEAN_W-1:0]     mean;
    } lane_out_t;

endpackage

FILE: hw/rtl/ghsd_lane.sv
// One foot: phase tracking, strike time, interval history and mean period.
// Update stage on accept, mean multiply into the output stage. Uses ghsd_pkg.
module ghsd_lane #(
    parameter int TIME_WIDTH = ghsd_pkg::TIME_WIDTH_DEF
) (
    input  logic                                  aclk,
    input  logic                                  aresetn,
    input  ghsd_pkg::pipe_ctrl_t                  ctrl,
    input  logic [TIME_WIDTH-1:0]                 time_in,
    input  logic signed [ghsd_pkg::SAMPLE_W-1:0]  force_in,
    input  logic signed [ghsd_pkg::SAMPLE_W-1:0]  slope_in,
    input  logic signed [ghsd_pkg::THR_W-1:0]     force_thr,
    input  logic signed [ghsd_pkg::THR_W-1:0]     slope_thr,
    output logic                                  strike,
    output ghsd_pkg::lane_out_t                   lane_out
);
    import ghsd_pkg::*;

    logic                  phase_reg, phase_next;
    logic [TIME_WIDTH-1:0] last_reg, last_next;
    // two newest entries; with the new interval they make the three summed
    logic [HIST_W-1:0]     hist_reg [2];
    logic [HIST_W-1:0]     sum_reg, sum_next;
    logic                  strike_a_reg;

    logic                  stance_b_reg;
    logic [TIME_OUT_W-1:0] time_b_reg;
    logic [MEAN_W-1:0]     mean_reg, mean_next;

    logic                  strike_cond, lift_cond;
    logic signed [THR_W:0] lift_sum;
    logic                  lift;
    logic [TIME_WIDTH-1:0] interval;
    logic [HIST_W-1:0]     iv_clamp;
    logic [HIST_W+1:0]     sum_raw;
    logic [31:0]           prod;

    always_comb begin
        strike_cond = (slope_in > slope_thr) && (force_in < force_thr);
        // slope < -thr at full precision
        lift_sum    = $signed({slope_in[SAMPLE_W-1], slope_in})
                    + $signed({slope_thr[THR_W-1], slope_thr});
        lift_cond   = (lift_sum < 0) && (force_in > force_thr);
        strike      = ctrl.a_load && !phase_reg && strike_cond;
        lift        = ctrl.a_load && phase_reg && lift_cond;

        interval = time_in - last_reg;
        if (interval > TIME_WIDTH'(INTERVAL_MAX)) begin
            iv_clamp = INTERVAL_MAX;
        end else begin
            iv_clamp = interval[HIST_W-1:0];
        end
        sum_raw = {2'b00, iv_clamp} + {2'b00, hist_reg[0]} + {2'b00, hist_reg[1]};
        if (sum_raw > {2'b00, INTERVAL_MAX}) begin
            sum_next = INTERVAL_MAX;
        end else begin
            sum_next = sum_raw[HIST_W-1:0];
        end

        phase_next = phase_reg;
        last_next  = last_reg;
        if (strike) begin
            phase_next = 1'b1;
            last_next  = time_in;
        end else if (lift) begin
            phase_next = 1'b0;
        end

        prod = 32'({1'b0, sum_reg} + 16'd1) * 32'(RECIP3);
        mean_next = strike_a_reg ? prod[RECIP3_SHIFT +: MEAN_W] : mean_reg;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            phase_reg    <= 1'b0;
            last_reg     <= '0;
            hist_reg[0]  <= '0;
            hist_reg[1]  <= '0;
            mean_reg     <= '0;
            strike_a_reg <= 1'b0;
        end else begin
            phase_reg <= phase_next;
            last_reg  <= last_next;
            if (strike) begin
                hist_reg[0] <= iv_clamp;
                hist_reg[1] <= hist_reg[0];
            end
            if (ctrl.a_load) begin
                strike_a_reg <= strike;
            end
            if (ctrl.b_load) begin
                mean_reg <= mean_next;
            end
        end
    end

    // payload, no reset
    always_ff @(posedge aclk) begin
        if (ctrl.a_load) begin
            sum_reg <= sum_next;
        end
        if (ctrl.b_load) begin
            stance_b_reg <= phase_reg;
            time_b_reg   <= TIME_OUT_W'(last_reg);
        end
    end

    assign lane_out.stance      = stance_b_reg;
    assign lane_out.strike_time = time_b_reg;
    assign lane_out.mean        = mean_reg;

endmodule

FILE: hw/rtl/ghsd_merge.sv
// Merge stage: prosthesis-side step counter, ready flag and result packing.
// Takes strike pulses and output-stage fields from both lanes. Uses ghsd_pkg.
module ghsd_merge #(
    parameter int STEPS_TO_READY = ghsd_pkg::STEPS_TO_READY_DEF
) (
    input  logic                              aclk,
    input  logic                              aresetn,
    input  ghsd_pkg::pipe_ctrl_t              ctrl,
    input  logic                              prosth_on_left,
    input  logic                              strike_left,
    input  logic                              strike_right,
    input  ghsd_pkg::lane_out_t               left_out,
    input  ghsd_pkg::lane_out_t               right_out,
    output logic [ghsd_pkg::M_TDATA_W-1:0]    m_tdata
);
    import ghsd_pkg::*;

    localparam int CNT_W = $clog2(STEPS_TO_READY + 1);
    localparam logic [CNT_W-1:0] STEPS_MAX = CNT_W'(STEPS_TO_READY);

    logic [CNT_W-1:0]  count_reg, count_next;
    logic              ready_reg, ready_next;
    logic [STEP_W-1:0] step_b_reg;
    logic              ready_b_reg;
    logic              step_hit;

    always_comb begin
        step_hit   = prosth_on_left ? strike_left : strike_right;
        count_next = count_reg;
        if (step_hit && (count_reg < STEPS_MAX)) begin
            count_next = count_reg + 1'b1;
        end
        ready_next = ready_reg || (step_hit && (count_next >= STEPS_MAX));
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            count_reg <= '0;
            ready_reg <= 1'b0;
        end else begin
            count_reg <= count_next;
            ready_reg <= ready_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (ctrl.b_load) begin
            step_b_reg  <= STEP_W'(count_reg);
            ready_b_reg <= ready_reg;
        end
    end

    always_comb begin
        m_tdata = '0;
        m_tdata[OUT_LST_BIT]                = left_out.stance;
        m_tdata[OUT_RST_BIT]                = right_out.stance;
        m_tdata[OUT_LT_LO +: TIME_OUT_W]    = left_out.strike_time;
        m_tdata[OUT_RT_LO +: TIME_OUT_W]    = right_out.strike_time;
        m_tdata[OUT_LM_LO +: MEAN_W]        = left_out.mean;
        m_tdata[OUT_RM_LO +: MEAN_W]        = right_out.mean;
        m_tdata[OUT_STEP_LO +: STEP_W]      = step_b_reg;
        m_tdata[OUT_RDY_BIT]                = ready_b_reg;
    end

endmodule

FILE: hw/rtl/gait_heel_strike_detector.sv
// Gait heel-strike detector: two foot lanes in parallel plus a merge stage.
// Pipeline: accepted item -> update stage -> output stage (mean) -> result valid.
// Throughput: 1 item per cycle while the output is not stalled; both lanes and
// the counter update in one stage.
// Reset: aresetn synchronous active low; clears phases, strike times, histories,
// means, step counter, ready flag, config registers and both valid stages.
module gait_heel_strike_detector #(
    parameter int STEPS_TO_READY = ghsd_pkg::STEPS_TO_READY_DEF,
    parameter int TIME_WIDTH     = ghsd_pkg::TIME_WIDTH_DEF
) (
    input  logic                               aclk,
    input  logic                               aresetn,
    input  logic                               cfg_wr_en,
    input  logic [ghsd_pkg::CFG_IDX_W-1:0]     cfg_index,
    input  logic [ghsd_pkg::THR_W-1:0]         cfg_wdata,
    input  logic                               s_tvalid,
    output logic                               s_tready,
    // time_count[31:0], left_force, left_slope, right_force, right_slope
    input  logic [ghsd_pkg::S_TDATA_W-1:0]     s_tdata,
    output logic                               m_tvalid,
    input  logic                               m_tready,
    // left_in_stance, right_in_stance, left_strike_time, right_strike_time,
    // left_mean_period, right_mean_period, step_count, detect_ready, zero pad
    output logic [ghsd_pkg::M_TDATA_W-1:0]     m_tdata
);
    import ghsd_pkg::*;

    logic signed [THR_W-1:0] lf_thr_reg, ls_thr_reg, rf_thr_reg, rs_thr_reg;
    logic                    prosth_left_reg;
    logic                    a_valid_reg, b_valid_reg;
    logic                    b_free;
    pipe_ctrl_t              ctrl;
    logic                    strike_left, strike_right;
    lane_out_t               left_out, right_out;
    logic [TIME_WIDTH-1:0]   time_in;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            lf_thr_reg      <= '0;
            ls_thr_reg      <= '0;
            rf_thr_reg      <= '0;
            rs_thr_reg      <= '0;
            prosth_left_reg <= 1'b0;
        end else if (cfg_wr_en) begin
            unique case (cfg_index)
                REG_LEFT_FORCE_THR:  lf_thr_reg      <= cfg_wdata;
                REG_LEFT_SLOPE_THR:  ls_thr_reg      <= cfg_wdata;
                REG_RIGHT_FORCE_THR: rf_thr_reg      <= cfg_wdata;
                REG_RIGHT_SLOPE_THR: rs_thr_reg      <= cfg_wdata;
                REG_PROSTH_ON_LEFT:  prosth_left_reg <= cfg_wdata[0];
                default: ;
            endcase
        end
    end

    always_comb begin
        b_free      = !b_valid_reg || m_tready;
        s_tready    = !a_valid_reg || b_free;
        ctrl.a_load = s_tvalid && s_tready;
        ctrl.b_load = a_valid_reg && b_free;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            a_valid_reg <= 1'b0;
            b_valid_reg <= 1'b0;
        end else begin
            if (ctrl.a_load) begin
                a_valid_reg <= 1'b1;
            end else if (ctrl.b_load) begin
                a_valid_reg <= 1'b0;
            end
            if (ctrl.b_load) begin
                b_valid_reg <= 1'b1;
            end else if (m_tready) begin
                b_valid_reg <= 1'b0;
            end
        end
    end

    assign m_tvalid = b_valid_reg;
    assign time_in  = TIME_WIDTH'(s_tdata[IN_TIME_LO +: TIME_OUT_W]);

    ghsd_lane #(.TIME_WIDTH(TIME_WIDTH)) u_left (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .ctrl      (ctrl),
        .time_in   (time_in),
        .force_in  (s_tdata[IN_LF_LO +: SAMPLE_W]),
        .slope_in  (s_tdata[IN_LS_LO +: SAMPLE_W]),
        .force_thr (lf_thr_reg),
        .slope_thr (ls_thr_reg),
        .strike    (strike_left),
        .lane_out  (left_out)
    );

    ghsd_lane #(.TIME_WIDTH(TIME_WIDTH)) u_right (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .ctrl      (ctrl),
        .time_in   (time_in),
        .force_in  (s_tdata[IN_RF_LO +: SAMPLE_W]),
        .slope_in  (s_tdata[IN_RS_LO +: SAMPLE_W]),
        .force_thr (rf_thr_reg),
        .slope_thr (rs_thr_reg),
        .strike    (strike_right),
        .lane_out  (right_out)
    );

    ghsd_merge #(.STEPS_TO_READY(STEPS_TO_READY)) u_merge (
        .aclk           (aclk),
        .aresetn        (aresetn),
        .ctrl           (ctrl),
        .prosth_on_left (prosth_left_reg),
        .strike_left    (strike_left),
        .strike_right   (strike_right),
        .left_out       (left_out),
        .right_out      (right_out),
        .m_tdata        (m_tdata)
    );

endmodule

FILE: hw/rtl/ghsd_checker.sv
// Port-level checks for gait_heel_strike_detector, attached by bind.
// Depends on ghsd_pkg for the result item layout.
module ghsd_checker (
    input logic                           aclk,
    input logic                           aresetn,
    input logic                           s_tvalid,
    input logic                           s_tready,
    input logic                           m_tvalid,
    input logic                           m_tready,
    input logic [ghsd_pkg::M_TDATA_W-1:0] m_tdata
);
    import ghsd_pkg::*;

    // stalled result holds
    a_out_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata))
        else $error("result item changed while stalled");

    // input only backs up when the output stage is full and stalled
    a_no_false_stall: assert property (@(posedge aclk) disable iff (!aresetn)
        !s_tready |-> m_tvalid && !m_tready)
        else $error("input stalled with room in the pipeline");

    // ready flag implies saturated step count
    a_ready_count: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && m_tdata[OUT_RDY_BIT]
        |-> m_tdata[OUT_STEP_LO +: STEP_W] == STEP_W'(STEPS_TO_READY_DEF))
        else $error("detect_ready set before step count saturated");

    // nothing valid right after reset
    a_reset_clear: assert property (@(posedge aclk)
        !aresetn |=> !m_tvalid)
        else $error("result valid after reset");

    // an accepted item reaches the output, via the update stage, when the output is empty
    a_latency: assert property (@(posedge aclk) disable iff (!aresetn)
        s_tvalid && s_tready && !m_tvalid |=> ##1 m_tvalid)
        else $error("result missing two cycles after accept");

endmodule

bind gait_heel_strike_detector ghsd_checker u_ghsd_checker (
    .aclk     (aclk),
    .aresetn  (aresetn),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata)
);
